>>> src/ftm_pkg.sv
// Package for the tabu list membership table.
// Holds the operation codes, the request type, register indexes and fixed widths.
// No dependencies.
`default_nettype none

package ftm_pkg;

  // Fixed field widths of the request and response channels.
  localparam int unsigned IN_KEY_W   = 10;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned CAPT_W     = 14;
  localparam int unsigned INIT_W     = 10;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  // Capacity saturation point, in tenths and split into whole and tenths.
  localparam logic [CAPT_W-1:0] CAP_TENTHS_MAX = 14'd16383;
  localparam logic [CAP_W-1:0]  CAP_WHOLE_MAX  = 11'd1638;
  localparam logic [3:0]        CAP_FRAC_MAX   = 4'd3;

  // Division of an 8-bit step by ten: (x * 205) >> 11 is exact below 1029.
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  // Reset values of the configuration registers.
  localparam logic [INIT_W-1:0] INIT_CAP_RST  = 10'd5;
  localparam logic [STEP_W-1:0] GROW_STEP_RST = 8'd11;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP = 1'd1;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_GROW   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [IN_KEY_W-1:0] first_key;
    logic [IN_KEY_W-1:0] second_key;
  } req_t;

endpackage

`default_nettype wire

>>> src/ftm_if.sv
// Channel interfaces of the tabu list membership table: request, response, configuration.
// Depends on ftm_pkg for the field widths.
`default_nettype none

interface ftm_req_if import ftm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [IN_KEY_W-1:0] first_key;
  logic [IN_KEY_W-1:0] second_key;

  modport source (output valid, output op, output first_key, output second_key, input ready);
  modport sink   (input valid, input op, input first_key, input second_key, output ready);
endinterface

interface ftm_rsp_if import ftm_pkg::*; #(parameter int unsigned CNT_W = 7) ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] live_count;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output hit, output live_count, output capacity, input ready);
  modport sink   (input valid, input hit, input live_count, input capacity, output ready);
endinterface

interface ftm_cfg_if import ftm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/ftm_capacity.sv
// Configuration registers and capacity bookkeeping of the tabu list.
// Keeps the capacity in tenths and as whole entries plus a tenths digit. Uses ftm_pkg, ftm_cfg_if.
`default_nettype none

module ftm_capacity import ftm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ftm_cfg_if.sink          cfg,
  input  logic             grow_i,
  output logic [CAP_W-1:0] cap_o,
  output logic [CAP_W-1:0] cap_next_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [4:0]        step_whole_q, step_whole_d;
  logic [3:0]        step_frac_q, step_frac_d;
  logic [CAPT_W-1:0] tenths_q, tenths_d;
  logic [CAP_W-1:0]  whole_q, whole_d;
  logic [3:0]        frac_q, frac_d;

  logic              cfg_wr;
  logic [15:0]       step_prod;
  logic [STEP_W-1:0] new_step;
  logic [INIT_W-1:0] new_init;
  logic [CAPT_W:0]   tenths_sum;
  logic [4:0]        frac_sum;
  logic              frac_carry;

  // Writes are always taken.
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;
  assign new_init  = cfg.data[INIT_W-1:0];
  assign new_step  = cfg.data[STEP_W-1:0];
  assign step_prod = {8'd0, new_step} * {8'd0, DIV10_MUL};

  // Grow arithmetic: tenths sum with saturation, and the split form with a carry.
  assign tenths_sum = {1'b0, tenths_q} + (CAPT_W+1)'(step_q);
  assign frac_sum   = {1'b0, frac_q} + {1'b0, step_frac_q};
  assign frac_carry = (frac_sum >= 5'd10);

  always_comb begin
    step_d       = step_q;
    step_whole_d = step_whole_q;
    step_frac_d  = step_frac_q;
    tenths_d     = tenths_q;
    whole_d      = whole_q;
    frac_d       = frac_q;
    if (cfg_wr) begin
      unique case (cfg.index)
        REG_INIT_CAP: begin
          tenths_d = CAPT_W'({4'd0, new_init} * 14'd10);
          whole_d  = CAP_W'(new_init);
          frac_d   = 4'd0;
        end
        REG_GROW_STEP: begin
          step_d       = new_step;
          step_whole_d = step_prod[DIV10_SHIFT +: 5];
          step_frac_d  = 4'(new_step - ({3'd0, step_prod[DIV10_SHIFT +: 5]} * 8'd10));
        end
        default: ;
      endcase
    end else if (grow_i) begin
      if (tenths_sum[CAPT_W]) begin
        tenths_d = CAP_TENTHS_MAX;
        whole_d  = CAP_WHOLE_MAX;
        frac_d   = CAP_FRAC_MAX;
      end else begin
        tenths_d = tenths_sum[CAPT_W-1:0];
        whole_d  = whole_q + CAP_W'(step_whole_q) + CAP_W'(frac_carry);
        frac_d   = frac_carry ? 4'(frac_sum - 5'd10) : frac_sum[3:0];
      end
    end
  end

  // Register bank; reset loads the default capacity and step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= GROW_STEP_RST;
      step_whole_q <= 5'd1;
      step_frac_q  <= 4'd1;
      tenths_q     <= CAPT_W'({4'd0, INIT_CAP_RST} * 14'd10);
      whole_q      <= CAP_W'(INIT_CAP_RST);
      frac_q       <= 4'd0;
    end else begin
      step_q       <= step_d;
      step_whole_q <= step_whole_d;
      step_frac_q  <= step_frac_d;
      tenths_q     <= tenths_d;
      whole_q      <= whole_d;
      frac_q       <= frac_d;
    end
  end

  assign cap_o      = whole_q;
  assign cap_next_o = whole_d;

endmodule

`default_nettype wire

>>> src/ftm_slots.sv
// Slot array of the tabu list: key registers, live marks, queue pointers and live count.
// Compares the pair against all slots in parallel and applies one operation per cycle
// while do_op_i is high. Uses ftm_pkg.
`default_nettype none

module ftm_slots import ftm_pkg::*; #(
  parameter  int unsigned SLOTS    = 64,
  parameter  int unsigned KEY_BITS = 10,
  localparam int unsigned SW       = $clog2(SLOTS),
  localparam int unsigned CW       = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             do_op_i,
  input  req_t             req_i,
  input  logic [CAP_W-1:0] cap_i,
  output logic             hit_o,
  output logic [CW-1:0]    count_o
);

  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;

  logic [KEY_BITS-1:0] key_a_q [SLOTS];
  logic [KEY_BITS-1:0] key_b_q [SLOTS];
  logic [SLOTS-1:0]    live_q, live_d;
  logic [SW-1:0]       oldest_q, oldest_d;
  logic [CW-1:0]       used_q, used_d;
  logic [CW-1:0]       total_q, total_d;

  logic [KEY_BITS-1:0] key_a, key_b, pop_a, pop_b;
  logic [SLOTS-1:0]    match, pop_match, tail_bit, live1, live2;
  logic                hit, full, drop, over, wr_en;
  logic [SW-1:0]       oldest1, tail;
  logic [SW:0]         tail_sum;
  logic [CW-1:0]       total2, used2;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign key_a = KEY_BITS'(req_i.first_key);
  assign key_b = KEY_BITS'(req_i.second_key);

  // Parallel lookup of the live pair.
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = live_q[s] && (key_a_q[s] == key_a) && (key_b_q[s] == key_b);
    end
  end
  assign hit = |match;

  // Insert path: drop the oldest slot when the queue is full, then append at the tail.
  assign full     = (used_q == CW'(SLOTS));
  assign drop     = full && live_q[oldest_q];
  assign oldest1  = full ? next_slot(oldest_q) : oldest_q;
  assign tail_sum = {1'b0, oldest_q} + (SW+1)'(used_q);
  always_comb begin
    if (full) begin
      tail = oldest_q;
    end else if (tail_sum >= (SW+1)'(SLOTS)) begin
      tail = SW'(tail_sum - (SW+1)'(SLOTS));
    end else begin
      tail = SW'(tail_sum);
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      tail_bit[s] = (SW'(s) == tail);
    end
  end

  always_comb begin
    live1 = live_q;
    if (full) begin
      live1[oldest_q] = 1'b0;
    end
  end
  assign live2  = live1 | tail_bit;
  assign total2 = total_q - CW'(drop) + CW'(1);
  assign used2  = full ? used_q : used_q + CW'(1);
  assign over   = (MW'(total2) > MW'(cap_i));

  // Pop path: the pair in the oldest slot, which is the new entry when the queue was empty.
  assign pop_a = (oldest1 == tail) ? key_a : key_a_q[oldest1];
  assign pop_b = (oldest1 == tail) ? key_b : key_b_q[oldest1];
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      if (tail_bit[s]) begin
        pop_match[s] = (key_a == pop_a) && (key_b == pop_b);
      end else begin
        pop_match[s] = live2[s] && (key_a_q[s] == pop_a) && (key_b_q[s] == pop_b);
      end
    end
  end

  // Next state for one operation.
  always_comb begin
    live_d   = live_q;
    oldest_d = oldest_q;
    used_d   = used_q;
    total_d  = total_q;
    wr_en    = 1'b0;
    if (do_op_i) begin
      case (req_i.op)
        OP_REMOVE: begin
          if (hit) begin
            live_d  = live_q & ~match;
            total_d = total_q - CW'(1);
          end
        end
        OP_ADD: begin
          if (!hit) begin
            wr_en = 1'b1;
            if (over) begin
              live_d   = live2 & ~pop_match;
              total_d  = total2 - CW'(|pop_match);
              oldest_d = next_slot(oldest1);
              used_d   = used2 - CW'(1);
            end else begin
              live_d   = live2;
              total_d  = total2;
              oldest_d = oldest1;
              used_d   = used2;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Queue control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q   <= '0;
      oldest_q <= '0;
      used_q   <= '0;
      total_q  <= '0;
    end else begin
      live_q   <= live_d;
      oldest_q <= oldest_d;
      used_q   <= used_d;
      total_q  <= total_d;
    end
  end

  // Key storage, written at the tail on an insert.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_a_q[tail] <= key_a;
      key_b_q[tail] <= key_b;
    end
  end

  assign hit_o   = hit && (req_i.op != OP_GROW);
  assign count_o = total_d;

endmodule

`default_nettype wire

>>> src/fifo_tabu_membership_table.sv
// Top level of the tabu list membership table.
// Instantiates ftm_capacity and ftm_slots; uses ftm_pkg and the channel interfaces.
//
//   Channel  Direction  Payload                          Handshake
//   req      in         op, first_key, second_key        valid / ready
//   rsp      out        hit, live_count, capacity        valid / ready
//   cfg      in         index, data                      valid / ready (ready held high)
//
// A request is registered on acceptance and processed once it is in the input
// register and the response register is free or being taken; its result is then
// registered in the response register.
// One request completes every cycle while responses are taken.
// A stalled response holds the output register, and the request side stops
// accepting once the input register is also occupied.
// Reset clears all live marks at once; the block is ready right after reset.
`default_nettype none

module fifo_tabu_membership_table import ftm_pkg::*; #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned KEY_BITS = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ftm_req_if.sink  req,
  ftm_rsp_if.source rsp,
  ftm_cfg_if.sink  cfg
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic             in_valid_q;
  req_t             in_req_q;
  logic             out_valid_q;
  logic             hit_q;
  logic [CW-1:0]    count_q;
  logic [CAP_W-1:0] cap_q;

  logic             advance;
  logic             grow;
  logic             hit;
  logic [CW-1:0]    count;
  logic [CAP_W-1:0] cap_cur, cap_next;

  assign advance   = in_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !in_valid_q || advance;
  assign grow      = advance && (in_req_q.op == OP_GROW);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.ready) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      in_req_q.op         <= op_e'(req.op);
      in_req_q.first_key  <= req.first_key;
      in_req_q.second_key <= req.second_key;
    end
  end

  ftm_capacity u_capacity (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg        (cfg),
    .grow_i     (grow),
    .cap_o      (cap_cur),
    .cap_next_o (cap_next)
  );

  ftm_slots #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_slots (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .do_op_i (advance),
    .req_i   (in_req_q),
    .cap_i   (cap_cur),
    .hit_o   (hit),
    .count_o (count)
  );

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q   <= hit;
      count_q <= count;
      cap_q   <= cap_next;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = hit_q;
  assign rsp.live_count = count_q;
  assign rsp.capacity   = cap_q;

endmodule

`default_nettype wire

>>> src/ftm_checker.sv
// Port-level checker for the tabu list membership table, bound to the top level.
// Depends on ftm_pkg for the field widths.
`default_nettype none

module ftm_checker import ftm_pkg::*; #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned CW    = 7
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic             rsp_hit,
  input wire logic [CW-1:0]    rsp_live_count,
  input wire logic [CAP_W-1:0] rsp_capacity
);

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
      $stable(rsp_live_count) && $stable(rsp_capacity))
    else $error("response changed while stalled");

  // Requests are only held off by a stalled response.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side blocked without a stalled response");

  // The live count never exceeds the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_live_count <= CW'(SLOTS))
    else $error("live count above slot count");

  // The capacity never passes its saturation point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_capacity <= CAP_WHOLE_MAX)
    else $error("capacity above saturation");

endmodule

bind fifo_tabu_membership_table ftm_checker #(
  .SLOTS (SLOTS),
  .CW    (CW)
) u_ftm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_live_count (rsp.live_count),
  .rsp_capacity   (rsp.capacity)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the tabu list membership table (fifo_tabu_membership_table).
// Drives requests and register writes through the channel interfaces and checks each response.
// Depends on ftm_pkg, the channel interfaces in ftm_if.sv and the top level of the block.
`default_nettype none

module tb_top;
  import ftm_pkg::*;

  localparam int SLOT_COUNT   = 64;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PRINT_LIMIT  = 100;
  localparam int HOLD_CYCLES  = 300;

  // Expected contents of one response.
  typedef struct {
    logic            hit;
    logic [6:0]      live_count;
    logic [CAP_W-1:0] capacity;
  } tabu_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ftm_req_if               req_ch ();
  ftm_rsp_if #(.CNT_W(7))  rsp_ch ();
  ftm_cfg_if               cfg_ch ();

  fifo_tabu_membership_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Requests waiting to be offered and responses waiting to arrive.
  req_t      pending_ops [$];
  tabu_rsp_t expected_rsps [$];

  int queued_cnt     = 0;
  int accepted_cnt   = 0;
  int answered_cnt   = 0;
  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_on      = 1'b0;
  logic req_taken    = 1'b0;
  logic cfg_taken    = 1'b0;

  // Shadow copy of the table: slot keys, live marks, queue pointers and capacity.
  logic [IN_KEY_W-1:0] slot_a [SLOT_COUNT];
  logic [IN_KEY_W-1:0] slot_b [SLOT_COUNT];
  bit                  slot_on [SLOT_COUNT];
  int head_slot   = 0;
  int used_slots  = 0;
  int live_cnt    = 0;
  int init_cap    = int'(INIT_CAP_RST);
  int grow_tenths = int'(GROW_STEP_RST);
  int cap_tenths  = int'(INIT_CAP_RST) * 10;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < PRINT_LIMIT)
      $display("tb_top: mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic tabu_rsp_t tabu_predict(input op_e op, input logic [IN_KEY_W-1:0] a,
                                             input logic [IN_KEY_W-1:0] b);
    tabu_rsp_t r;
    int pos;
    int tail;
    logic [IN_KEY_W-1:0] pa;
    logic [IN_KEY_W-1:0] pb;
    r.hit = 1'b0;
    if (op == OP_GROW) begin
      cap_tenths = cap_tenths + grow_tenths;
      if (cap_tenths > int'(CAP_TENTHS_MAX))
        cap_tenths = int'(CAP_TENTHS_MAX);
    end else begin
      pos = -1;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (pos < 0 && slot_on[s] && slot_a[s] == a && slot_b[s] == b)
          pos = s;
      end
      r.hit = (pos >= 0);
      if (op == OP_REMOVE && r.hit) begin
        slot_on[pos] = 1'b0;
        live_cnt--;
      end else if (op == OP_ADD && !r.hit) begin
        // A full queue loses its oldest slot before the insert.
        if (used_slots == SLOT_COUNT) begin
          if (slot_on[head_slot]) begin
            slot_on[head_slot] = 1'b0;
            live_cnt--;
          end
          head_slot = (head_slot + 1) % SLOT_COUNT;
          used_slots--;
        end
        tail = (head_slot + used_slots) % SLOT_COUNT;
        slot_a[tail]  = a;
        slot_b[tail]  = b;
        slot_on[tail] = 1'b1;
        used_slots++;
        live_cnt++;
        // Over capacity: pop the oldest slot once and clear every live copy of its pair.
        if (live_cnt > cap_tenths / 10) begin
          pa = slot_a[head_slot];
          pb = slot_b[head_slot];
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (slot_on[s] && slot_a[s] == pa && slot_b[s] == pb) begin
              slot_on[s] = 1'b0;
              live_cnt--;
            end
          end
          head_slot = (head_slot + 1) % SLOT_COUNT;
          used_slots--;
        end
      end
    end
    r.live_count = 7'(live_cnt);
    r.capacity   = CAP_W'(cap_tenths / 10);
    return r;
  endfunction

  // Handshake monitor: checks responses, tracks register writes, predicts accepted requests.
  always @(posedge clk_i) begin
    tabu_rsp_t want;
    req_taken <= req_ch.valid && req_ch.ready;
    cfg_taken <= cfg_ch.valid && cfg_ch.ready;
    if (rsp_ch.valid && rsp_ch.ready) begin
      answered_cnt <= answered_cnt + 1;
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected response, live_count", rsp_ch.live_count, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.hit !== want.hit)
          report_mismatch("hit", rsp_ch.hit, want.hit);
        if (rsp_ch.live_count !== want.live_count)
          report_mismatch("live_count", rsp_ch.live_count, want.live_count);
        if (rsp_ch.capacity !== want.capacity)
          report_mismatch("capacity", rsp_ch.capacity, want.capacity);
      end
    end
    if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_INIT_CAP) begin
        init_cap   = int'(cfg_ch.data[INIT_W-1:0]);
        cap_tenths = init_cap * 10;
      end else if (cfg_ch.index == REG_GROW_STEP) begin
        grow_tenths = int'(cfg_ch.data[STEP_W-1:0]);
      end
    end
    if (req_ch.valid && req_ch.ready) begin
      accepted_cnt <= accepted_cnt + 1;
      expected_rsps = {expected_rsps, tabu_predict(op_e'(req_ch.op), req_ch.first_key,
                                                   req_ch.second_key)};
    end
  end

  // Request driver: offers the next pending request once the previous one was taken.
  always @(negedge clk_i) begin
    req_t nxt;
    if (rst_ni && (!req_ch.valid || req_taken)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_ops.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.op         <= nxt.op;
        req_ch.first_key  <= nxt.first_key;
        req_ch.second_key <= nxt.second_key;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls, plus a long hold-off when requested.
  always @(negedge clk_i) begin
    rsp_ch.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic queue_op(input op_e op, input logic [IN_KEY_W-1:0] a,
                          input logic [IN_KEY_W-1:0] b);
    req_t r;
    r.op         = op;
    r.first_key  = a;
    r.second_key = b;
    pending_ops = {pending_ops, r};
    queued_cnt++;
  endtask

  // Random request: keys mostly from a small pool so that pairs repeat.
  function automatic req_t rand_tabu_req(input int key_span, input int grow_pct);
    req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < grow_pct)
      r.op = OP_GROW;
    else if (pick < grow_pct + (100 - grow_pct) * 45 / 100)
      r.op = OP_ADD;
    else if (pick < grow_pct + (100 - grow_pct) * 75 / 100)
      r.op = OP_CHECK;
    else
      r.op = OP_REMOVE;
    if ($urandom_range(7) == 0) begin
      r.first_key  = IN_KEY_W'($urandom);
      r.second_key = IN_KEY_W'($urandom);
    end else begin
      r.first_key  = IN_KEY_W'($urandom_range(key_span));
      r.second_key = IN_KEY_W'($urandom_range(key_span));
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every queued request is accepted and answered, then lets the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk_i); while (accepted_cnt != queued_cnt || answered_cnt < accepted_cnt);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int init_val, input int step_val, input int send_pct,
                           input int stall_pct, input int n_ops, input int key_span,
                           input int grow_pct);
    write_reg(REG_INIT_CAP, CFG_DATA_W'(init_val));
    write_reg(REG_GROW_STEP, {2'($urandom_range(3)), STEP_W'(step_val)});
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_ops; i++)
      pending_ops = {pending_ops, rand_tabu_req(key_span, grow_pct)};
    queued_cnt += n_ops;
    wait_drained();
  endtask

  initial begin
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_CHECK;
    req_ch.first_key  = '0;
    req_ch.second_key = '0;
    rsp_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_INIT_CAP;
    cfg_ch.data       = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings: re-add of a live pair, removal of an absent
    // pair, a stale slot left by a remove, and an over-capacity pop of that stale slot
    // which clears the live copy of its pair.
    queue_op(OP_CHECK, 10'd0, 10'd0);
    queue_op(OP_ADD, 10'd0, 10'd0);
    queue_op(OP_ADD, 10'd0, 10'd0);
    queue_op(OP_CHECK, 10'd0, 10'd0);
    queue_op(OP_REMOVE, 10'd1023, 10'd1023);
    queue_op(OP_ADD, 10'd1023, 10'd1023);
    queue_op(OP_CHECK, 10'd1023, 10'd1023);
    queue_op(OP_REMOVE, 10'd0, 10'd0);
    queue_op(OP_CHECK, 10'd0, 10'd0);
    queue_op(OP_ADD, 10'd0, 10'd0);
    queue_op(OP_GROW, 10'd1023, 10'd0);
    queue_op(OP_ADD, 10'd1023, 10'd0);
    queue_op(OP_ADD, 10'd0, 10'd1023);
    queue_op(OP_ADD, 10'h155, 10'h2AA);
    queue_op(OP_ADD, 10'h2AA, 10'h155);
    queue_op(OP_ADD, 10'd1, 10'd2);
    queue_op(OP_CHECK, 10'd0, 10'd0);
    queue_op(OP_REMOVE, 10'd1023, 10'd1023);
    queue_op(OP_ADD, 10'd3, 10'd3);
    queue_op(OP_CHECK, 10'd1023, 10'd0);
    queue_op(OP_GROW, 10'd0, 10'd1023);
    wait_drained();

    // Zero capacity with no growth: every add inserts and pops at once.
    run_phase(0, 0, 0, 0, 250, 3, 5);
    // Largest initial capacity: the slot queue fills and drops its oldest slot on insert.
    run_phase(1023, 255, 51, 0, 300, 15, 10);
    // Many grows from a large start drive the capacity into saturation.
    run_phase(1023, 200, 0, 51, 250, 15, 40);
    run_phase(3, 7, 10, 10, 300, 4, 10);

    // Long response hold-off while requests keep coming, so the block backs up.
    fork
      begin
        @(posedge clk_i);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on = 1'b0;
      end
    join_none
    run_phase(20, 1, 0, 0, 300, 7, 10);

    run_phase(8, 128, 51, 0, 300, 5, 10);
    run_phase(64, 11, 0, 51, 300, 12, 5);

    if (expected_rsps.size() != 0)
      report_mismatch("responses never returned", 0, expected_rsps.size());
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
